// ----- hw/rtl/rwsc_pkg.sv -----
// Shared types, codes and substitution tables of the rotor word stream cipher.
package rwsc_pkg;

  localparam int WORD_W      = 16;
  localparam int NUM_ROTORS  = 8;
  localparam int ROTOR_IDX_W = 3;
  localparam int INIT_PASSES = 4;
  localparam int PASS_W      = 2;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int KEY_W       = 256;
  localparam int IV_W        = 128;
  localparam int KEY_PAIR_W  = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        nib_t;
  typedef logic [1:0]        mode_t;
  typedef logic [1:0]        op_t;

  localparam mode_t MODE_INIT = 2'd0;
  localparam mode_t MODE_ENC  = 2'd1;
  localparam mode_t MODE_DEC  = 2'd2;

  localparam op_t OP_INIT = 2'd0;
  localparam op_t OP_ENC  = 2'd1;
  localparam op_t OP_DEC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;

  localparam word_t LFSR_TAPS = 16'hCA44;
  localparam word_t SEED_BIT  = 16'h0100;

  localparam nib_t FWD_SB [4][16] = '{
    '{4'h1, 4'hF, 4'hB, 4'h2, 4'h0, 4'h3, 4'h5, 4'h8,
      4'h6, 4'h9, 4'hC, 4'h7, 4'hD, 4'hA, 4'hE, 4'h4},
    '{4'h6, 4'hA, 4'hF, 4'h4, 4'hE, 4'hD, 4'h9, 4'h2,
      4'h1, 4'h7, 4'hC, 4'hB, 4'h0, 4'h3, 4'h5, 4'h8},
    '{4'hC, 4'h2, 4'h6, 4'h1, 4'h0, 4'h3, 4'h5, 4'h8,
      4'h7, 4'h9, 4'hB, 4'hE, 4'hA, 4'hD, 4'hF, 4'h4},
    '{4'hD, 4'hB, 4'h2, 4'h7, 4'h0, 4'h3, 4'h5, 4'h8,
      4'h6, 4'hC, 4'hF, 4'h1, 4'hA, 4'h4, 4'h9, 4'hE}
  };

  localparam nib_t INV_SB [4][16] = '{
    '{4'h4, 4'h0, 4'h3, 4'h5, 4'hF, 4'h6, 4'h8, 4'hB,
      4'h7, 4'h9, 4'hD, 4'h2, 4'hA, 4'hC, 4'hE, 4'h1},
    '{4'hC, 4'h8, 4'h7, 4'hD, 4'h3, 4'hE, 4'h0, 4'h9,
      4'hF, 4'h6, 4'h1, 4'hB, 4'hA, 4'h5, 4'h4, 4'h2},
    '{4'h4, 4'h3, 4'h1, 4'h5, 4'hF, 4'h6, 4'h2, 4'h8,
      4'h7, 4'h9, 4'hC, 4'hA, 4'h0, 4'hD, 4'hB, 4'hE},
    '{4'h4, 4'hB, 4'h2, 4'h5, 4'hD, 4'h6, 4'h8, 4'h3,
      4'h7, 4'hE, 4'hC, 4'h1, 4'h9, 4'h0, 4'hF, 4'hA}
  };

  typedef struct packed {
    op_t   op;
    word_t word;
  } rwsc_item_t;

  typedef struct packed {
    logic       valid;
    rwsc_item_t item;
  } rwsc_q_t;

endpackage

// ----- hw/rtl/rwsc_front.sv -----
// Input acceptance, mode classification and the item queue toward the sequencer.
module rwsc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rwsc_pkg::mode_t  mode,
  input  rwsc_pkg::word_t  data_word,
  output rwsc_pkg::rwsc_q_t q,
  input  logic             q_pop
);
  import rwsc_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  rwsc_item_t          entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  rwsc_item_t          item_in;
  logic                keep;
  logic                push;

  always_comb begin
    item_in.word = data_word;
    item_in.op   = OP_INIT;
    keep         = 1'b1;
    case (mode)
      MODE_INIT: item_in.op = OP_INIT;
      MODE_ENC:  item_in.op = OP_ENC;
      MODE_DEC:  item_in.op = OP_DEC;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 1'b1;
    end else if (!push && q_pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  assign q.valid = (count != '0);
  assign q.item  = entries[rd_ptr];

endmodule

// ----- hw/rtl/rwsc_block.sv -----
// One keyed five-round SPN block, forward and inverse, selected per step.
module rwsc_block (
  input  rwsc_pkg::word_t                       x,
  input  logic [rwsc_pkg::KEY_PAIR_W-1:0]       key_pair,
  input  logic [rwsc_pkg::ROTOR_IDX_W-1:0]      idx,
  input  logic                                  dec,
  output rwsc_pkg::word_t                       y
);
  import rwsc_pkg::*;

  function automatic word_t rol16(input word_t v, input int s);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << s;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t sub_fwd(input word_t v);
    return {FWD_SB[0][v[15:12]], FWD_SB[1][v[11:8]], FWD_SB[2][v[7:4]], FWD_SB[3][v[3:0]]};
  endfunction

  function automatic word_t sub_inv(input word_t v);
    return {INV_SB[0][v[15:12]], INV_SB[1][v[11:8]], INV_SB[2][v[7:4]], INV_SB[3][v[3:0]]};
  endfunction

  function automatic word_t lin_fwd(input word_t v);
    nib_t  a, b, c, d;
    word_t p;
    a = v[15:12];
    b = v[11:8];
    c = v[7:4];
    d = v[3:0];
    a = a ^ c;
    b = b ^ d;
    c = c ^ b;
    d = d ^ a;
    p = {a, b, c, d};
    return p ^ rol16(p, 12) ^ rol16(p, 8);
  endfunction

  function automatic word_t lin_inv(input word_t v);
    nib_t  a, b, c, d;
    word_t p;
    p = v ^ rol16(v, 4) ^ rol16(v, 8);
    a = p[15:12];
    b = p[11:8];
    c = p[7:4];
    d = p[3:0];
    d = d ^ a;
    c = c ^ b;
    b = b ^ d;
    a = a ^ c;
    return {a, b, c, d};
  endfunction

  // OR the nibble into the rotated word, do not replace it
  function automatic word_t derive(input word_t k, input int rot, input word_t tweak);
    word_t r;
    r = rol16(k, rot);
    r = r | {6'b0, FWD_SB[0][r[9:6]], 6'b0};
    return r ^ tweak;
  endfunction

  word_t k0, k1, k2, k3;
  word_t enc_y, dec_y;
  word_t e1, e2, e3, e4;
  word_t d1, d2, d3, d4;

  assign k0 = key_pair[WORD_W-1:0];
  assign k1 = key_pair[2*WORD_W-1:WORD_W];
  assign k2 = derive(k0, 6, WORD_W'(idx) + 16'd3);
  assign k3 = derive(k1, 10, WORD_W'(idx) + 16'd4);

  assign e1    = lin_fwd(sub_fwd(x ^ k0)) ^ k1;
  assign e2    = lin_fwd(sub_fwd(e1)) ^ k2;
  assign e3    = lin_fwd(sub_fwd(e2)) ^ k3;
  assign e4    = lin_fwd(sub_fwd(e3)) ^ k1 ^ k0;
  assign enc_y = sub_fwd(e4) ^ k2 ^ k3;

  assign d1    = sub_inv(x ^ k3 ^ k2) ^ k0 ^ k1;
  assign d2    = sub_inv(lin_inv(d1)) ^ k3;
  assign d3    = sub_inv(lin_inv(d2)) ^ k2;
  assign d4    = sub_inv(lin_inv(d3)) ^ k1;
  assign dec_y = sub_inv(lin_inv(d4)) ^ k0;

  assign y = dec ? dec_y : enc_y;

endmodule

// ----- hw/rtl/rwsc_back.sv -----
// Sequencer: rotor state, chain walk over the shared block, state update and result register.
module rwsc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rwsc_pkg::rwsc_q_t           q,
  output logic                        q_pop,
  input  logic [rwsc_pkg::KEY_W-1:0]  key,
  input  logic [rwsc_pkg::IV_W-1:0]   iv,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rwsc_pkg::word_t             result_word,
  output logic                        from_decrypt
);
  import rwsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  localparam logic [ROTOR_IDX_W-1:0] LAST_IDX  = ROTOR_IDX_W'(NUM_ROTORS - 1);
  localparam logic [PASS_W-1:0]      LAST_PASS = PASS_W'(INIT_PASSES - 1);

  logic [2:0]             state;
  op_t                    op;
  logic [ROTOR_IDX_W-1:0] step;
  logic [PASS_W-1:0]      pass;
  word_t                  rotor [NUM_ROTORS];
  word_t                  lfsr;
  word_t                  chain;
  word_t                  chain_v [NUM_ROTORS-1];

  logic [ROTOR_IDX_W-1:0] idx;
  logic                   dec;
  word_t                  b_add;
  word_t                  x_sum;
  word_t                  blk_x;
  word_t                  blk_y;
  word_t                  nv;
  logic                   out_free;
  logic                   upd_go;

  word_t n0, n1, n2, n3, n4a, n4, n5, n6, n7, lfsr_next;

  assign dec      = (op == OP_DEC);
  assign idx      = dec ? (LAST_IDX - step) : step;
  assign b_add    = (op == OP_INIT && step == '0) ? '0 : rotor[idx];
  assign x_sum    = chain + b_add;
  assign blk_x    = dec ? chain : x_sum;
  assign nv       = dec ? (blk_y - rotor[idx]) : blk_y;
  assign out_free = !out_valid || !out_stall;
  assign upd_go   = (state == S_UPD) && out_free;
  assign q_pop    = (state == S_IDLE) && q.valid;

  rwsc_block u_block (
    .x        (blk_x),
    .key_pair (key[{idx, 5'd0} +: KEY_PAIR_W]),
    .idx      (idx),
    .dec      (dec),
    .y        (blk_y)
  );

  always_comb begin
    n1        = rotor[1] + chain_v[0] + chain_v[4] + rotor[5];
    n2        = rotor[2] + chain_v[1] + chain_v[2] + rotor[3] + rotor[0];
    n3        = rotor[3] + chain_v[0] + chain_v[3] + rotor[7];
    n4a       = rotor[4] + chain_v[1];
    n5        = rotor[5] + chain_v[0] + chain_v[3] + rotor[6];
    n6        = rotor[6] + chain_v[1] + chain_v[5];
    n7        = rotor[7] + chain_v[3];
    n0        = rotor[0] + chain_v[2] + chain_v[1] + n4a + chain_v[6];
    lfsr_next = {1'b0, lfsr[WORD_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
    n4        = n4a + lfsr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_INIT;
      step      <= '0;
      pass      <= '0;
      rotor     <= '{default: '0};
      lfsr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !upd_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q.valid) begin
            op   <= q.item.op;
            step <= '0;
            pass <= '0;
            if (q.item.op == OP_INIT) begin
              for (int i = 0; i < NUM_ROTORS; i++) begin
                rotor[i] <= iv[i*WORD_W +: WORD_W];
              end
              state <= S_SUM;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_SUM: begin
          step  <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          if (op == OP_INIT && step != '0) begin
            rotor[idx] <= x_sum;
          end
          step <= step + 1'b1;
          if (step == LAST_IDX) begin
            state <= (op == OP_INIT) ? S_FOLD : S_UPD;
          end
        end
        S_FOLD: begin
          rotor[0] <= rotor[0] + chain;
          if (pass == LAST_PASS) begin
            lfsr  <= chain | SEED_BIT;
            state <= S_IDLE;
          end else begin
            pass  <= pass + 1'b1;
            state <= S_SUM;
          end
        end
        S_UPD: begin
          if (out_free) begin
            rotor[0]  <= n0;
            rotor[1]  <= n1;
            rotor[2]  <= n2;
            rotor[3]  <= n3;
            rotor[4]  <= n4;
            rotor[5]  <= n5;
            rotor[6]  <= n6;
            rotor[7]  <= n7;
            lfsr      <= lfsr_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      chain <= q.item.word;
    end
    if (state == S_SUM) begin
      chain <= rotor[0] + rotor[2] + rotor[4] + rotor[6];
    end
    if (state == S_STEP) begin
      chain <= nv;
      if (!dec && idx != LAST_IDX) begin
        chain_v[idx] <= nv;
      end
      if (dec && idx != '0) begin
        chain_v[idx - 1'b1] <= nv;
      end
    end
    if (upd_go) begin
      result_word  <= chain;
      from_decrypt <= dec;
    end
  end

endmodule

// ----- hw/rtl/rotor_word_stream_cipher_unit.sv -----
// Top level of the rotor word stream cipher: configuration registers, front and back.
//
// Input channel (in_valid, in_stall, mode, data_word): an item is taken at a
// clock edge with in_valid high and in_stall low. Mode initialise loads the IV
// and runs four chained passes; encrypt and decrypt give one result each; the
// unused mode code is taken and dropped.
// Output channel (out_valid, out_stall, result_word, from_decrypt): one result
// per encrypt or decrypt item, in order, held in a register until taken.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (key words
// A to D, then nonce low and high); unused indexes are ignored. Write only
// while the block is idle. Key changes apply at once, IV changes at the next
// initialise.
// Timing: a two-entry queue takes items while the sequencer works. One shared
// keyed block walks the eight rotor words, one word per cycle: encrypt and
// decrypt go through dequeue, 8 block steps and a state update that also loads
// the result register. Initialise goes through dequeue plus 4 passes of sum,
// 8 steps and fold, and gives no result.
// A stalled result holds the update step, and then the queue fills and raises
// in_stall. Reset clears the queue, the rotor words, the LFSR, the registers
// and the output.
module rotor_word_stream_cipher_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rwsc_pkg::mode_t                   mode,
  input  rwsc_pkg::word_t                   data_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rwsc_pkg::word_t                   result_word,
  output logic                              from_decrypt,
  input  logic                              cfg_wr_en,
  input  logic [rwsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rwsc_pkg::CFG_W-1:0]        cfg_data
);
  import rwsc_pkg::*;

  logic [CFG_W-1:0] key_a, key_b, key_c, key_d;
  logic [CFG_W-1:0] nonce_low, nonce_high;
  rwsc_q_t          q;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a      <= '0;
      key_b      <= '0;
      key_c      <= '0;
      key_d      <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_A:      key_a      <= cfg_data;
        CFG_KEY_B:      key_b      <= cfg_data;
        CFG_KEY_C:      key_c      <= cfg_data;
        CFG_KEY_D:      key_d      <= cfg_data;
        CFG_NONCE_LOW:  nonce_low  <= cfg_data;
        CFG_NONCE_HIGH: nonce_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rwsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_word (data_word),
    .q         (q),
    .q_pop     (q_pop)
  );

  rwsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q            (q),
    .q_pop        (q_pop),
    .key          ({key_d, key_c, key_b, key_a}),
    .iv           ({nonce_high, nonce_low}),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_word  (result_word),
    .from_decrypt (from_decrypt)
  );

endmodule

// ----- hw/rtl/rwsc_checker.sv -----
// Port-level checks of the rotor word stream cipher top level and their binding.
module rwsc_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_stall,
  input  logic            out_valid,
  input  logic            out_stall,
  input  rwsc_pkg::word_t result_word,
  input  logic            from_decrypt
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_word) && $stable(from_decrypt))
    else $error("stalled result changed or dropped");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) ##1 (out_valid && !out_stall) |=> !(out_valid && !out_stall))
    else $error("results delivered faster than the block walk allows");

endmodule

bind rotor_word_stream_cipher_unit rwsc_checker u_rwsc_checker (.*);
